[sv/utf8sv_pkg.sv]
// ----------------------------------------------------------------------------
// utf8sv_pkg
// Shared types and constants for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package utf8sv_pkg;

	localparam int unsigned SCALAR_W = 21;

	// Smallest legal scalar of the open sequence, by lead byte length.
	typedef enum logic [1:0] {
		CLS_NONE  = 2'd0,
		CLS_TWO   = 2'd1,
		CLS_THREE = 2'd2,
		CLS_FOUR  = 2'd3
	} min_class_t;

	localparam logic [7:0] LEAD2_LO  = 8'hC2;
	localparam logic [7:0] LEAD2_HI  = 8'hDF;
	localparam logic [7:0] LEAD3_LO  = 8'hE0;
	localparam logic [7:0] LEAD3_HI  = 8'hEF;
	localparam logic [7:0] LEAD4_LO  = 8'hF0;
	localparam logic [7:0] LEAD4_HI  = 8'hF4;
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;
	localparam logic [7:0] ASCII_TOP = 8'h80;

	localparam logic [SCALAR_W-1:0] SCALAR_MAX = 21'h10FFFF;
	localparam logic [SCALAR_W-1:0] SURR_LO    = 21'h00D800;
	localparam logic [SCALAR_W-1:0] SURR_HI    = 21'h00DFFF;

	typedef struct packed {
		logic buffer_end;
		logic buffer_valid;
		logic error_seen;
	} result_t;

	function automatic logic [SCALAR_W-1:0] min_of_class(input min_class_t cls);
		logic [SCALAR_W-1:0] m;
		unique case (cls)
			CLS_NONE:  m = 21'h000000;
			CLS_TWO:   m = 21'h000080;
			CLS_THREE: m = 21'h000800;
			CLS_FOUR:  m = 21'h010000;
			default:   m = 21'h000000;
		endcase
		return m;
	endfunction

endpackage

[sv/utf8sv_decode.sv]
// ----------------------------------------------------------------------------
// utf8sv_decode
// Per-buffer decoder state and the combinational step that checks one byte.
// ----------------------------------------------------------------------------
module utf8sv_decode
	import utf8sv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_value,
	input  logic       last_byte,
	output result_t    result
);

	logic [1:0]          pend_q;
	logic [SCALAR_W-1:0] acc_q;
	min_class_t          cls_q;
	logic                sticky_q;

	logic [1:0]          pend_n;
	logic [SCALAR_W-1:0] acc_n;
	min_class_t          cls_n;
	logic                sticky_n;
	logic                byte_err;
	logic [SCALAR_W-1:0] acc_shift;
	logic                scalar_ok;

	assign acc_shift = {acc_q[SCALAR_W-7:0], byte_value[5:0]};
	assign scalar_ok = (acc_shift >= min_of_class(cls_q)) && (acc_shift <= SCALAR_MAX)
		&& !((acc_shift >= SURR_LO) && (acc_shift <= SURR_HI));

	always_comb begin
		pend_n   = pend_q;
		acc_n    = acc_q;
		cls_n    = cls_q;
		byte_err = 1'b0;
		if (!sticky_q) begin
			if (pend_q != 2'd0) begin
				if ((byte_value & CONT_MASK) != CONT_TAG) begin
					byte_err = 1'b1;
				end else if (pend_q == 2'd1) begin
					// Sequence completes on this word; judge the scalar and drop it.
					byte_err = !scalar_ok;
					pend_n   = 2'd0;
					acc_n    = '0;
					cls_n    = CLS_NONE;
				end else begin
					pend_n = pend_q - 2'd1;
					acc_n  = acc_shift;
				end
			end else if (byte_value == 8'h00) begin
				byte_err = 1'b1;
			end else if (byte_value < ASCII_TOP) begin
				byte_err = 1'b0;
			end else if (byte_value >= LEAD2_LO && byte_value <= LEAD2_HI) begin
				acc_n  = {16'd0, byte_value[4:0]};
				pend_n = 2'd1;
				cls_n  = CLS_TWO;
			end else if (byte_value >= LEAD3_LO && byte_value <= LEAD3_HI) begin
				acc_n  = {17'd0, byte_value[3:0]};
				pend_n = 2'd2;
				cls_n  = CLS_THREE;
			end else if (byte_value >= LEAD4_LO && byte_value <= LEAD4_HI) begin
				acc_n  = {18'd0, byte_value[2:0]};
				pend_n = 2'd3;
				cls_n  = CLS_FOUR;
			end else begin
				byte_err = 1'b1;
			end
		end
		sticky_n = sticky_q;
		if (byte_err) begin
			sticky_n = 1'b1;
			pend_n   = 2'd0;
			acc_n    = '0;
			cls_n    = CLS_NONE;
		end
		// A sequence still open at the end of the buffer is truncated.
		if (last_byte && pend_n != 2'd0) begin
			sticky_n = 1'b1;
		end
	end

	assign result.buffer_end   = last_byte;
	assign result.buffer_valid = last_byte && !sticky_n;
	assign result.error_seen   = sticky_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 2'd0;
			acc_q    <= '0;
			cls_q    <= CLS_NONE;
			sticky_q <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				pend_q   <= 2'd0;
				acc_q    <= '0;
				cls_q    <= CLS_NONE;
				sticky_q <= 1'b0;
			end else begin
				pend_q   <= pend_n;
				acc_q    <= acc_n;
				cls_q    <= cls_n;
				sticky_q <= sticky_n;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_byte |=> (pend_q == 2'd0) && !sticky_q && (cls_q == CLS_NONE))
		else $error("decoder state not cleared after last word");
	a_sticky_no_seq: assert property (@(posedge clk) disable iff (!arst_n)
		sticky_q |-> (pend_q == 2'd0))
		else $error("open sequence kept after an error");
	a_class_tracks_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == 2'd0) == (cls_q == CLS_NONE))
		else $error("sequence class out of step with pending count");
	a_hold_without_step: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(pend_q) && $stable(sticky_q))
		else $error("decoder state moved without a step");
`endif

endmodule

[sv/utf8_stream_validator.sv]
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Strict UTF-8 checker for a byte stream, one byte per word.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one buffer byte per word,
// with last_byte set on the final byte of each buffer. The output channel
// (out_valid/out_ready) returns one word for every input word: error_seen
// tells whether an error has occurred so far in the buffer, and on the word
// that answers the last byte buffer_end is set and buffer_valid reports
// whether the whole buffer was strict UTF-8 with no NUL byte. Decoder state
// clears after every last byte, so buffers follow each other without a gap.
// A word accepted on the input channel is registered in the input register,
// decoded, and stored in the result register, which offers it on the output
// channel. Throughput is one word per clock while out_ready stays high, with
// a combinational decode step between the input and result registers.
// When the receiver stalls, the result register holds its word, the input
// register fills, and in_ready drops until out_ready returns.
// Reset clears both valid flags and the decoder; no clearing pass is needed.
// ----------------------------------------------------------------------------
module utf8_stream_validator
	import utf8sv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_value,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       buffer_end,
	output logic       buffer_valid,
	output logic       error_seen
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       out_valid_q;
	result_t    result_q;
	result_t    result;
	logic       advance;

	// The stage moves on when the result register is empty or being taken.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= byte_value;
			last_s1 <= last_byte;
		end
	end

	utf8sv_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.byte_value (byte_s1),
		.last_byte  (last_s1),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign buffer_end   = result_q.buffer_end;
	assign buffer_valid = result_q.buffer_valid;
	assign error_seen   = result_q.error_seen;

`ifndef NO_ASSERTIONS
	a_valid_only_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_q.buffer_end |-> !result_q.buffer_valid)
		else $error("buffer_valid raised on a word that is not a buffer end");
	a_valid_excludes_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.buffer_valid |-> !result_q.error_seen)
		else $error("buffer reported valid with an error seen");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !advance)
		else $error("stalled result word overwritten");
`endif

endmodule
